>>> hw/rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the burst ring buffer: transfer layouts,
// operation and result codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

   // field widths
   localparam int MODE_W    = 2;
   localparam int CNT_W     = 10;
   localparam int BYTE_W    = 8;
   localparam int GRANT_W   = 7;

   // parameter defaults
   localparam int DEPTH_DEF     = 512;
   localparam int MAX_BURST_DEF = 64;

   // capacity after reset
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(512);

   // request operation codes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   // result kind codes
   localparam logic [MODE_W-1:0] KIND_WRITE_ACK = 2'd0;
   localparam logic [MODE_W-1:0] KIND_READ      = 2'd1;
   localparam logic [MODE_W-1:0] KIND_CLEAR_ACK = 2'd2;

   // request transfer
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CNT_W-1:0]  burst_length;
      logic              first_of_burst;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   // result transfer
   typedef struct packed {
      logic [MODE_W-1:0]  kind;
      logic [BYTE_W-1:0]  out_byte;
      logic [GRANT_W-1:0] granted;
      logic               last;
      logic [CNT_W-1:0]   fill_level;
   } rsp_item_type;

   // result fields held while the store read is under way
   typedef struct packed {
      logic [MODE_W-1:0]  kind;
      logic [GRANT_W-1:0] granted;
      logic               last;
      logic [CNT_W-1:0]   fill_level;
      logic               from_store;
   } rsp_meta_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/byte_ring_buffer_burst.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst
// Circular byte buffer with all-or-nothing write bursts and contiguous
// chunked reads, the bytes held in one RAM with registered read.
// ----------------------------------------------------------------------------
// Results: the first result of a transfer is registered and appears in the
// cycle after it is accepted; further bytes of a read chunk follow one per
// cycle. Busy: write, clear and empty-read requests never raise busy; a read
// of n bytes holds busy until its last RAM read is issued, one read per byte.
// Reset: pointers, fill count and burst flag clear at once, capacity returns
// to 512; the byte store is not cleared and there is no start-up sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_burst #(
   parameter int DEPTH     = brb_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       start,
   output logic                            busy,
   input  wire brb_pkg::req_item_type      req_data,
   // result channel
   output logic                            rsp_strobe,
   output brb_pkg::rsp_item_type           rsp_data,
   // configuration
   input  wire logic                       csr_we,
   input  wire logic [brb_pkg::CNT_W-1:0]  csr_wdata
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW  = $clog2(DEPTH + 1);
   localparam int XW  = ((DW > brb_pkg::CNT_W) ? DW : brb_pkg::CNT_W) + 1;
   localparam int RW  = $clog2(MAX_BURST + 1);
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
   localparam logic [XW-1:0] MAXB_X  = XW'(MAX_BURST);

   // state registers
   brb_pkg::state_type          state_ff, state_in;
   logic [brb_pkg::CNT_W-1:0]   capacity_ff, capacity_in;
   logic [AW-1:0]               rp_ff, rp_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [brb_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic                        burst_ok_ff, burst_ok_in;
   logic [RW-1:0]               remain_ff, remain_in;
   logic [brb_pkg::GRANT_W-1:0] grant_ff, grant_in;
   logic                        strobe_ff, strobe_in;
   brb_pkg::rsp_meta_type       meta_ff, meta_in;

   // working values
   logic                        accept;
   logic [XW-1:0]               cap_x, fill_x, rp_x, wp_x, len_x;
   logic [XW-1:0]               n1, n2, n_x, room_x;
   logic                        first_ok, wr_ok, issue;
   logic [RW-1:0]               rem_before, rem_after;
   logic [brb_pkg::GRANT_W-1:0] grant_cur;
   logic [brb_pkg::BYTE_W-1:0]  ram_rdata;
   logic                        ram_we;

   assign accept = start && !busy;
   assign busy   = (state_ff == brb_pkg::ST_READ);

   // effective ring size, clamped to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_x = XW'(1);
      end else if (XW'(capacity_ff) > DEPTH_X) begin
         cap_x = DEPTH_X;
      end else begin
         cap_x = XW'(capacity_ff);
      end
   end

   assign fill_x = XW'(fill_ff);
   assign rp_x   = XW'(rp_ff);
   assign wp_x   = XW'(wp_ff);
   assign len_x  = XW'(req_data.burst_length);

   // burst admission and per-byte write check
   assign first_ok = (len_x != '0) && ((cap_x - fill_x) >= len_x);
   always_comb begin
      burst_ok_in = burst_ok_ff;
      if (accept && req_data.mode == brb_pkg::MODE_WRITE && req_data.first_of_burst) begin
         burst_ok_in = first_ok;
      end
   end
   assign wr_ok  = burst_ok_in && (fill_x < cap_x) && (wp_x < cap_x);
   assign ram_we = accept && (req_data.mode == brb_pkg::MODE_WRITE) && wr_ok;

   // chunk length of a read request
   assign n1     = (len_x > MAXB_X) ? MAXB_X : len_x;
   assign n2     = (n1 > fill_x) ? fill_x : n1;
   assign room_x = cap_x - rp_x;
   always_comb begin
      if (rp_x >= cap_x) begin
         n_x = '0;
      end else if (n2 > room_x) begin
         n_x = room_x;
      end else begin
         n_x = n2;
      end
   end

   // store read issue, first byte in the request cycle, then one per cycle
   assign issue = (accept && req_data.mode == brb_pkg::MODE_READ && n_x != '0) || busy;
   assign rem_before = busy ? remain_ff : RW'(n_x);
   assign grant_cur  = busy ? grant_ff : brb_pkg::GRANT_W'(n_x);
   assign rem_after  = rem_before - RW'(1);

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      capacity_in = capacity_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      remain_in   = remain_ff;
      grant_in    = grant_ff;
      strobe_in   = 1'b0;
      meta_in     = meta_ff;

      if (issue) begin
         // one byte of a read chunk
         rp_in      = ((rp_x + XW'(1)) >= cap_x) ? '0 : rp_ff + AW'(1);
         fill_in    = fill_ff - brb_pkg::CNT_W'(1);
         remain_in  = rem_after;
         grant_in   = grant_cur;
         state_in   = (rem_after != '0) ? brb_pkg::ST_READ : brb_pkg::ST_IDLE;
         strobe_in  = 1'b1;
         meta_in.kind       = brb_pkg::KIND_READ;
         meta_in.granted    = grant_cur;
         meta_in.last       = (rem_after == '0);
         meta_in.fill_level = fill_in;
         meta_in.from_store = 1'b1;
      end else if (accept) begin
         unique case (req_data.mode)
            brb_pkg::MODE_WRITE: begin
               if (wr_ok) begin
                  wp_in   = ((wp_x + XW'(1)) >= cap_x) ? '0 : wp_ff + AW'(1);
                  fill_in = fill_ff + brb_pkg::CNT_W'(1);
               end
               strobe_in          = 1'b1;
               meta_in.kind       = brb_pkg::KIND_WRITE_ACK;
               meta_in.granted    = brb_pkg::GRANT_W'(wr_ok);
               meta_in.last       = 1'b0;
               meta_in.fill_level = fill_in;
               meta_in.from_store = 1'b0;
            end
            brb_pkg::MODE_READ: begin
               // empty read: nothing to fetch
               strobe_in          = 1'b1;
               meta_in.kind       = brb_pkg::KIND_READ;
               meta_in.granted    = '0;
               meta_in.last       = 1'b1;
               meta_in.fill_level = fill_ff;
               meta_in.from_store = 1'b0;
            end
            brb_pkg::MODE_CLEAR: begin
               rp_in              = '0;
               wp_in              = '0;
               fill_in            = '0;
               strobe_in          = 1'b1;
               meta_in.kind       = brb_pkg::KIND_CLEAR_ACK;
               meta_in.granted    = '0;
               meta_in.last       = 1'b0;
               meta_in.fill_level = '0;
               meta_in.from_store = 1'b0;
            end
            brb_pkg::MODE_NONE: begin
               // unused code, no result
            end
            default: begin
            end
         endcase
      end

      // capacity write empties the ring
      if (csr_we) begin
         capacity_in = csr_wdata;
         rp_in       = '0;
         wp_in       = '0;
         fill_in     = '0;
      end
   end

   // burst flag: reads and clears end a burst, capacity writes drop it
   logic burst_flag_in;
   always_comb begin
      burst_flag_in = burst_ok_in;
      if (accept && (req_data.mode == brb_pkg::MODE_READ ||
                     req_data.mode == brb_pkg::MODE_CLEAR)) begin
         burst_flag_in = 1'b0;
      end
      if (csr_we) begin
         burst_flag_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= brb_pkg::ST_IDLE;
         capacity_ff <= brb_pkg::CAP_RESET;
         rp_ff       <= '0;
         wp_ff       <= '0;
         fill_ff     <= '0;
         burst_ok_ff <= 1'b0;
         remain_ff   <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         capacity_ff <= capacity_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         burst_ok_ff <= burst_flag_in;
         remain_ff   <= remain_in;
         strobe_ff   <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      grant_ff <= grant_in;
      meta_ff  <= meta_in;
   end

   // byte store
   brb_ram #(
      .WIDTH (brb_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_data.data_byte),
      .rd_en   (issue),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   // result transfer
   assign rsp_strobe          = strobe_ff;
   assign rsp_data.kind       = meta_ff.kind;
   assign rsp_data.out_byte   = meta_ff.from_store ? ram_rdata : '0;
   assign rsp_data.granted    = meta_ff.granted;
   assign rsp_data.last       = meta_ff.last;
   assign rsp_data.fill_level = meta_ff.fill_level;

endmodule

`default_nettype wire

>>> hw/rtl/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_byte_ring_buffer_burst.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_burst
// Self-checking bench for the burst ring buffer. Requests go in over the
// start/busy port and a local model of the ring predicts every result. The
// results are compared field by field, in order. Directed tests cover the
// burst and read rules. Random traffic then runs across a sweep of capacity
// settings, with sender gaps and drain pauses.
// ----------------------------------------------------------------------------

module tb_byte_ring_buffer_burst;

   timeunit 1ns;
   timeprecision 1ps;

   import brb_pkg::*;

   localparam int RING_DEPTH     = DEPTH_DEF;
   localparam int CHUNK_MAX      = MAX_BURST_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 3;

   // dut ports
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               start      = 1'b0;
   logic               busy;
   req_item_type       req_data   = '0;
   logic               rsp_strobe;
   rsp_item_type       rsp_data;
   logic               csr_we     = 1'b0;
   logic [CNT_W-1:0]   csr_wdata  = '0;

   // ring model state
   logic [CNT_W-1:0]   cap_reg;
   logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
   int unsigned        rd_ptr;
   int unsigned        wr_ptr;
   int unsigned        fill_cnt;
   bit                 burst_ok;

   // results waiting to arrive, oldest first
   rsp_item_type       pending_rsp [$];

   // bookkeeping
   int unsigned        mismatches     = 0;
   int unsigned        requests_sent  = 0;
   int unsigned        results_seen   = 0;
   int unsigned        cap_settings   = 1;
   int unsigned        quiet_cycles   = 0;
   int unsigned        calm_run       = 0;
   bit                 gaps_enabled   = 1'b1;

   byte_ring_buffer_burst dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // ring model
   // ---------------------------------------------------------------------

   function automatic int unsigned ring_size();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > RING_DEPTH) c = RING_DEPTH;
      return c;
   endfunction

   function automatic void empty_ring();
      rd_ptr   = 0;
      wr_ptr   = 0;
      fill_cnt = 0;
      burst_ok = 1'b0;
   endfunction

   // works out the results of one accepted request and queues them
   function automatic void predict_ring_access(input req_item_type item);
      int unsigned  c;
      int unsigned  n;
      bit           ok;
      rsp_item_type r;
      c = ring_size();
      r = '0;
      case (item.mode)
         MODE_WRITE: begin
            if (item.first_of_burst)
               burst_ok = (item.burst_length != 0) && (c - fill_cnt >= item.burst_length);
            ok = burst_ok && (fill_cnt < c) && (wr_ptr < c);
            if (ok) begin
               ring_mem[wr_ptr] = item.data_byte;
               wr_ptr = (wr_ptr + 1 >= c) ? 0 : wr_ptr + 1;
               fill_cnt++;
            end
            r.kind       = KIND_WRITE_ACK;
            r.granted    = GRANT_W'(ok);
            r.fill_level = CNT_W'(fill_cnt);
            pending_rsp.push_back(r);
         end
         MODE_READ: begin
            burst_ok = 1'b0;
            n = item.burst_length;
            if (n > CHUNK_MAX) n = CHUNK_MAX;
            if (n > fill_cnt) n = fill_cnt;
            // a chunk never runs past the physical end of the ring
            if (rd_ptr >= c) n = 0;
            else if (n > c - rd_ptr) n = c - rd_ptr;
            r.kind = KIND_READ;
            if (n == 0) begin
               r.last       = 1'b1;
               r.fill_level = CNT_W'(fill_cnt);
               pending_rsp.push_back(r);
            end else begin
               for (int unsigned i = 0; i < n; i++) begin
                  r.out_byte   = ring_mem[rd_ptr];
                  rd_ptr       = (rd_ptr + 1 >= c) ? 0 : rd_ptr + 1;
                  fill_cnt--;
                  r.granted    = GRANT_W'(n);
                  r.last       = (i + 1 == n);
                  r.fill_level = CNT_W'(fill_cnt);
                  pending_rsp.push_back(r);
               end
            end
         end
         MODE_CLEAR: begin
            empty_ring();
            r.kind = KIND_CLEAR_ACK;
            pending_rsp.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns: %s", $time, msg);
   endtask

   rsp_item_type got_rsp;
   rsp_item_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_rsp = rsp_data;
         results_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %p", got_rsp));
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (got_rsp.kind !== want_rsp.kind)
               report_mismatch($sformatf("kind %0d, expected %0d",
                                         got_rsp.kind, want_rsp.kind));
            if (got_rsp.out_byte !== want_rsp.out_byte)
               report_mismatch($sformatf("out_byte %0h, expected %0h",
                                         got_rsp.out_byte, want_rsp.out_byte));
            if (got_rsp.granted !== want_rsp.granted)
               report_mismatch($sformatf("granted %0d, expected %0d",
                                         got_rsp.granted, want_rsp.granted));
            if (got_rsp.last !== want_rsp.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         got_rsp.last, want_rsp.last));
            if (got_rsp.fill_level !== want_rsp.fill_level)
               report_mismatch($sformatf("fill_level %0d, expected %0d",
                                         got_rsp.fill_level, want_rsp.fill_level));
         end
      end
   end

   // watchdog on cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_item_type make_req(input logic [MODE_W-1:0] mode,
                                             input int unsigned len,
                                             input bit first,
                                             input int unsigned data);
      req_item_type item;
      item.mode           = mode;
      item.burst_length   = CNT_W'(len);
      item.first_of_burst = first;
      item.data_byte      = BYTE_W'(data);
      return item;
   endfunction

   task automatic idle_cycles(input int unsigned n);
      start    <= 1'b0;
      req_data <= req_item_type'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // random sender gaps, with calm stretches in between
   task automatic sender_gap();
      if (!gaps_enabled) return;
      if (calm_run > 0) begin
         calm_run--;
      end else if ($urandom_range(0, 9) == 0) begin
         calm_run = $urandom_range(5, 15);
      end else if ($urandom_range(0, 2) == 0) begin
         idle_cycles($urandom_range(1, 4));
      end
   endtask

   // one request transfer; start is left high for a following request
   task automatic send_request(input req_item_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_ring_access(item);
      if (item.mode != MODE_NONE) requests_sent++;
      sender_gap();
   endtask

   task automatic send_burst(input int unsigned len, input int unsigned nbytes);
      for (int unsigned i = 0; i < nbytes; i++)
         send_request(make_req(MODE_WRITE, len, i == 0, $urandom));
   endtask

   // sender holds off until every queued result has come back
   task automatic drain_results();
      if (start) start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input int unsigned value);
      drain_results();
      // an ignored request may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CNT_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_reg = CNT_W'(value);
      empty_ring();
      cap_settings++;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // empty read straight after reset, unused mode, clear
   task automatic test_reset_state();
      send_request(make_req(MODE_READ, 5, 0, 0));
      send_request(make_req(MODE_NONE, 1023, 1, 8'hff));
      send_request(make_req(MODE_CLEAR, 0, 0, 0));
   endtask

   // zero length, stray byte, oversize burst, then a good burst read back
   task automatic test_write_burst_rules();
      send_request(make_req(MODE_WRITE, 0, 1, 8'hff));
      send_request(make_req(MODE_WRITE, 1, 0, 8'h00));
      send_request(make_req(MODE_WRITE, 1023, 1, 8'h81));
      send_request(make_req(MODE_WRITE, 3, 1, 8'h00));
      send_request(make_req(MODE_WRITE, 3, 0, 8'hff));
      send_request(make_req(MODE_WRITE, 3, 0, 8'h5a));
      send_request(make_req(MODE_READ, 1023, 0, 0));
   endtask

   // overrun on a full ring, a read cut at the ring end, interleaved burst
   task automatic test_overrun_and_interleave();
      set_capacity(4);
      send_request(make_req(MODE_WRITE, 4, 1, 8'h11));
      send_request(make_req(MODE_WRITE, 4, 0, 8'h22));
      send_request(make_req(MODE_WRITE, 4, 0, 8'h33));
      send_request(make_req(MODE_WRITE, 4, 0, 8'h44));
      send_request(make_req(MODE_WRITE, 4, 0, 8'h55));
      send_request(make_req(MODE_READ, 3, 0, 0));
      send_request(make_req(MODE_WRITE, 2, 1, 8'hc3));
      send_request(make_req(MODE_READ, 64, 0, 0));
      send_request(make_req(MODE_WRITE, 2, 0, 8'h3c));
      send_request(make_req(MODE_READ, 64, 0, 0));
      send_request(make_req(MODE_CLEAR, 512, 1, 8'hff));
   endtask

   // random traffic, mostly whole bursts and reads, some broken sequences
   task automatic run_traffic(input int unsigned cap_value, input int unsigned n_items);
      int unsigned target;
      int unsigned c;
      int unsigned free;
      int unsigned len;
      int unsigned pick;
      set_capacity(cap_value);
      target = requests_sent + n_items;
      while (requests_sent < target) begin
         c    = ring_size();
         free = c - fill_cnt;
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            // well-formed burst
            case ($urandom_range(0, 5))
               0:       len = (free > 0 && free <= 48) ? free : 1;
               1:       len = $urandom_range(1, (c < 48) ? c : 48);
               default: len = $urandom_range(1, (c < 8) ? c : 8);
            endcase
            send_burst(len, len);
         end else if (pick < 15) begin
            len = ($urandom_range(0, 3) == 0) ? ($urandom & 10'h3ff) : $urandom_range(0, 70);
            send_request(make_req(MODE_READ, len, 1'($urandom), $urandom));
         end else if (pick == 15) begin
            send_request(make_req(MODE_CLEAR, $urandom, 1'($urandom), $urandom));
         end else if (pick == 16) begin
            // burst too long for the free space
            len = free + 1 + $urandom_range(0, 3);
            if (len > 1023) len = 1023;
            send_burst(len, (len < 4) ? len : 4);
         end else if (pick == 17) begin
            // burst cut short by a read
            len = $urandom_range(2, 8);
            send_burst(len, $urandom_range(1, len - 1));
            send_request(make_req(MODE_READ, $urandom_range(0, 70), 0, $urandom));
            send_request(make_req(MODE_WRITE, len, 0, $urandom));
         end else if (pick == 18) begin
            // more bytes than announced
            len = $urandom_range(1, 6);
            send_burst(len, len + $urandom_range(1, 3));
         end else begin
            send_request(make_req(MODE_WRITE, $urandom, 0, $urandom));
            send_request(make_req(MODE_NONE, $urandom, 1'($urandom), $urandom));
         end
         if ($urandom_range(0, 15) == 0) drain_results();
      end
   endtask

   task automatic test_capacity_sweep();
      int unsigned settings [8] = '{0, 1, 2, 7, 1023, 600, 33, 3};
      foreach (settings[i]) run_traffic(settings[i], 18);
   endtask

   // closing traffic at full size with no sender gaps
   task automatic test_closing_traffic();
      gaps_enabled = 1'b0;
      run_traffic(512, 20);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      cap_reg = CAP_RESET;
      empty_ring();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_write_burst_rules();
      test_overrun_and_interleave();
      test_capacity_sweep();
      test_closing_traffic();

      drain_results();
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));

      $display("run covered %0d requests and %0d results over %0d capacity settings,",
               requests_sent, results_seen, cap_settings);
      $display("including settings 0 and 1023 clamped to 1 and 512, with %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
